// File: rtl/hmac_sha256_engine_defines.svh
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine assertion macros
// Concurrent check wrappers shared by the engine RTL.
// ----------------------------------------------------------------------------
`ifndef HMAC_SHA256_ENGINE_DEFINES_SVH
`define HMAC_SHA256_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define HSE_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hse assertion failed");
// condition must never be seen out of reset
`define HSE_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("hse forbidden condition");
`else
`define HSE_ASSERT(name, clk, rst, prop)
`define HSE_NEVER(name, clk, rst, cond)
`endif

`endif

// File: rtl/hse_pkg.sv
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine package
// Shared types, SHA-256 constants and round functions.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int KEY_REGS = 8;
  localparam int KEY_IDX_W = 3;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [31:0] OUTER_LEN = 32'd768;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // one queued message word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } item_t;

  // queue head as seen by the core
  typedef struct packed {
    logic  avail;
    item_t item;
  } q_head_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BYTE,
    S_CHECK,
    S_PAD,
    S_LENBLK,
    S_INNER,
    S_OUTMSG,
    S_MAC,
    S_CLOAD,
    S_ROUND,
    S_CADD
  } hse_state_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big0(input logic [31:0] x);
    big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] x);
    big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // key word i (of sixteen) xored with a pad byte
  function automatic logic [31:0] pad_word(input logic [511:0] key_block, input int i,
                                           input logic [7:0] pad);
    pad_word = key_block[511 - 32 * i -: 32] ^ {4{pad}};
  endfunction

endpackage

// File: rtl/hse_front.sv
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine front end
// Accepts message words, drops idle ones and queues the rest for the core.
// ----------------------------------------------------------------------------
module hse_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            msg_valid,
  output logic            msg_ready,
  input  hse_pkg::item_t  msg_item,
  input  logic            pop,
  output hse_pkg::q_head_t head
);
  import hse_pkg::*;

  item_t              mem [QDEPTH];
  logic [QPTR_W-1:0]  wp;
  logic [QPTR_W-1:0]  rp;
  logic [QCNT_W-1:0]  cnt;
  logic               push;

  assign msg_ready = (cnt != QCNT_W'(QDEPTH));
  // words with neither a byte nor an end marker do nothing
  assign push = msg_valid && msg_ready && (msg_item.byte_valid || msg_item.last);

  assign head.avail = (cnt != '0);
  assign head.item  = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= msg_item;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

`include "hmac_sha256_engine_defines.svh"
  `HSE_NEVER(a_cnt_ovf, clk, rst, cnt > QCNT_W'(QDEPTH))
  `HSE_NEVER(a_pop_empty, clk, rst, pop && (cnt == '0))
  `HSE_ASSERT(a_cnt_up, clk, rst, (push && !pop) |=> (cnt == $past(cnt) + 1'b1))

endmodule

// File: rtl/hse_core.sv
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine core
// Sequencer, block buffer and one-round-per-cycle SHA-256 compression unit.
// ----------------------------------------------------------------------------
module hse_core (
  input  logic             clk,
  input  logic             rst,
  input  logic [511:0]     key_block,
  input  hse_pkg::q_head_t head,
  output logic             pop,
  output logic             mac_valid,
  input  logic             mac_ready,
  output logic [63:0]      mac_word,
  output logic [1:0]       word_index,
  output logic             last_word
);
  import hse_pkg::*;

  hse_state_t   state;
  hse_state_t   state_next;
  hse_state_t   ret;
  hse_state_t   ret_next;
  item_t        cur;
  item_t        src;
  logic [31:0]  w [16];
  logic [31:0]  h [8];
  logic [31:0]  v [8];
  logic [31:0]  inner [8];
  logic [5:0]   rnd;
  logic [5:0]   fill;
  logic [63:0]  bit_count;
  logic [63:0]  fin_len;
  logic         open;
  logic [1:0]   k;
  logic         out_free;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  sched;

  // byte source: queue head when taken straight from idle, else the held word
  assign src = (state == S_IDLE) ? head.item : cur;
  assign out_free = !mac_valid || mac_ready;
  assign fin_len = bit_count + {55'd0, fill, 3'd0};

  // round datapath
  always_comb begin
    t1 = v[7] + big1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[rnd] + w[0];
    t2 = big0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    sched = sig1(w[14]) + w[9] + sig0(w[1]) + w[0];
  end

  // next state
  always_comb begin
    state_next = state;
    ret_next   = ret;
    pop        = 1'b0;
    case (state)
      S_IDLE: begin
        if (head.avail) begin
          pop = 1'b1;
          if (!open) begin
            state_next = S_CLOAD;
            ret_next   = S_BYTE;
          end else if (src.byte_valid && (fill == 6'd63)) begin
            state_next = S_CLOAD;
            ret_next   = S_CHECK;
          end else begin
            state_next = src.last ? S_PAD : S_IDLE;
          end
        end
      end
      S_BYTE: begin
        if (src.byte_valid && (fill == 6'd63)) begin
          state_next = S_CLOAD;
          ret_next   = S_CHECK;
        end else begin
          state_next = src.last ? S_PAD : S_IDLE;
        end
      end
      S_CHECK:  state_next = cur.last ? S_PAD : S_IDLE;
      S_PAD: begin
        state_next = S_CLOAD;
        ret_next   = (fill >= 6'd56) ? S_LENBLK : S_INNER;
      end
      S_LENBLK: begin
        state_next = S_CLOAD;
        ret_next   = S_INNER;
      end
      S_INNER: begin
        state_next = S_CLOAD;
        ret_next   = S_OUTMSG;
      end
      S_OUTMSG: begin
        state_next = S_CLOAD;
        ret_next   = S_MAC;
      end
      S_MAC:    if (out_free && (k == 2'd3)) state_next = S_IDLE;
      S_CLOAD:  state_next = S_ROUND;
      S_ROUND:  if (rnd == 6'd63) state_next = S_CADD;
      S_CADD:   state_next = ret;
      default:  state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // datapath and sequencer actions
  always_ff @(posedge clk) begin
    if (rst) begin
      open      <= 1'b0;
      fill      <= '0;
      bit_count <= '0;
      rnd       <= '0;
      k         <= '0;
      mac_valid <= 1'b0;
    end else begin
      if (mac_valid && mac_ready) mac_valid <= 1'b0;
      case (state)
        S_IDLE, S_BYTE: begin
          if (state == S_IDLE && head.avail) cur <= head.item;
          if (state == S_IDLE && head.avail && !open) begin
            // open: inner pad block under the current key
            for (int i = 0; i < 8; i++) h[i] <= IV[i];
            for (int i = 0; i < 16; i++) w[i] <= pad_word(key_block, i, IPAD);
            bit_count <= BLOCK_BITS;
            fill      <= '0;
            open      <= 1'b1;
          end else if ((state == S_BYTE || head.avail) && src.byte_valid) begin
            w[fill[5:2]][{~fill[1:0], 3'd0} +: 8] <= src.data_byte;
            fill <= fill + 1'b1;
            if (fill == 6'd63) bit_count <= bit_count + BLOCK_BITS;
          end
        end
        S_PAD: begin
          // end marker, zero tail, length when it fits
          bit_count <= fin_len;
          for (int p = 0; p < 64; p++) begin
            if (6'(p) == fill) w[p / 4][8 * (3 - p % 4) +: 8] <= PAD_BYTE;
            else if (6'(p) > fill) w[p / 4][8 * (3 - p % 4) +: 8] <= 8'd0;
          end
          if (fill < 6'd56) begin
            w[14] <= fin_len[63:32];
            w[15] <= fin_len[31:0];
          end
        end
        S_LENBLK: begin
          for (int i = 0; i < 14; i++) w[i] <= '0;
          w[14] <= bit_count[63:32];
          w[15] <= bit_count[31:0];
        end
        S_INNER: begin
          for (int i = 0; i < 8; i++) begin
            inner[i] <= h[i];
            h[i]     <= IV[i];
          end
          for (int i = 0; i < 16; i++) w[i] <= pad_word(key_block, i, OPAD);
        end
        S_OUTMSG: begin
          for (int i = 0; i < 8; i++) w[i] <= inner[i];
          w[8] <= {PAD_BYTE, 24'd0};
          for (int i = 9; i < 15; i++) w[i] <= '0;
          w[15] <= OUTER_LEN;
        end
        S_MAC: begin
          if (out_free) begin
            mac_valid  <= 1'b1;
            mac_word   <= {h[{k, 1'b0}], h[{k, 1'b1}]};
            word_index <= k;
            last_word  <= (k == 2'd3);
            k          <= k + 1'b1;
            if (k == 2'd3) begin
              open      <= 1'b0;
              fill      <= '0;
              bit_count <= '0;
            end
          end
        end
        S_CLOAD: begin
          for (int i = 0; i < 8; i++) v[i] <= h[i];
          rnd <= '0;
        end
        S_ROUND: begin
          v[0] <= t1 + t2;
          v[1] <= v[0];
          v[2] <= v[1];
          v[3] <= v[2];
          v[4] <= v[3] + t1;
          v[5] <= v[4];
          v[6] <= v[5];
          v[7] <= v[6];
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= sched;
          rnd <= rnd + 1'b1;
        end
        S_CADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
        end
        default: ;
      endcase
    end
  end

`include "hmac_sha256_engine_defines.svh"
  `HSE_ASSERT(a_fill_closed, clk, rst, !open |-> (fill == '0))
  `HSE_ASSERT(a_round_run, clk, rst, (state == S_ROUND && rnd != 6'd63) |=> (state == S_ROUND))
  `HSE_ASSERT(a_word_tag, clk, rst, mac_valid |-> (last_word == (word_index == 2'd3)))

endmodule

// File: rtl/hmac_sha256_engine.sv
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine
// Streams message bytes and returns the 256-bit MAC as four 64-bit words.
//
// channel  handshake             payload
// msg      msg_valid/msg_ready   data_byte, byte_valid, last
// mac      mac_valid/mac_ready   mac_word, word_index, last_word
// cfg      cfg_we                cfg_index, cfg_data (key words 0..7)
//
// Bytes are taken from the queue while no compression runs; every 64th byte adds a
// compression (load, 64 rounds, add) and a check step, run by the single shared
// SHA-256 round unit.
// Opening a message costs one compression; the end marker costs three or four
// more (pad, optional length block, outer pad, outer digest) plus four output
// words. A 4-entry queue decouples input from the core.
// rst is synchronous and clears control state and key registers.
// ----------------------------------------------------------------------------
module hmac_sha256_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        last,
  output logic        mac_valid,
  input  logic        mac_ready,
  output logic [63:0] mac_word,
  output logic [1:0]  word_index,
  output logic        last_word,
  input  logic        cfg_we,
  input  logic [hse_pkg::KEY_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data
);
  import hse_pkg::*;

  logic [63:0] key_reg [KEY_REGS];
  logic [511:0] key_block;
  item_t        msg_item;
  q_head_t      head;
  logic         pop;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_REGS; i++) key_reg[i] <= '0;
    end else if (cfg_we) begin
      key_reg[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_REGS; i++) key_block[511 - 64 * i -: 64] = key_reg[i];
  end

  assign msg_item = '{data_byte: data_byte, byte_valid: byte_valid, last: last};

  hse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg_item  (msg_item),
    .pop       (pop),
    .head      (head)
  );

  hse_core u_core (
    .clk        (clk),
    .rst        (rst),
    .key_block  (key_block),
    .head       (head),
    .pop        (pop),
    .mac_valid  (mac_valid),
    .mac_ready  (mac_ready),
    .mac_word   (mac_word),
    .word_index (word_index),
    .last_word  (last_word)
  );

endmodule

// File: tb/tb_hmac_sha256_engine.sv
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine testbench
// Streams directed and random messages under several keys, predicts each MAC
// with a behavioral SHA-256 and checks every output word in order, while
// both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_hmac_sha256_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import hse_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [63:0] mac_word;
    logic [1:0]  word_index;
    logic        last_word;
  } mac_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic msg_valid = 1'b0;
  logic msg_ready;
  logic [7:0] data_byte = 8'd0;
  logic byte_valid = 1'b0;
  logic last = 1'b0;
  logic mac_valid;
  logic mac_ready = 1'b0;
  logic [63:0] mac_word;
  logic [1:0] word_index;
  logic last_word;
  logic cfg_we = 1'b0;
  logic [KEY_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = 64'd0;

  item_t word_q[$];
  mac_t mac_exp[$];
  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_start = 1'b0;
  int hold_left = 0;

  // predictor state
  logic [63:0] key_now [KEY_REGS];
  logic [255:0] hash_st;
  logic [511:0] blk_buf;
  int fill;
  logic [63:0] bit_cnt;
  bit msg_open;

  hmac_sha256_engine dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one SHA-256 compression; words packed first word at the top
  function automatic logic [255:0] sha_compress(input logic [255:0] h, input logic [511:0] b);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int r = 0; r < 16; r++) w[r] = b[511 - 32 * r -: 32];
    for (int r = 16; r < 64; r++) begin
      s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = s1 + w[r-7] + s0 + w[r-16];
    end
    for (int i = 0; i < 8; i++) v[i] = h[255 - 32 * i -: 32];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h[255 - 32 * i -: 32] = h[255 - 32 * i -: 32] + v[i];
    return h;
  endfunction

  function automatic logic [255:0] iv_packed();
    logic [255:0] h;
    for (int i = 0; i < 8; i++) h[255 - 32 * i -: 32] = IV[i];
    return h;
  endfunction

  function automatic logic [511:0] key_pad(input logic [7:0] pad);
    logic [511:0] k;
    for (int i = 0; i < KEY_REGS; i++) k[511 - 64 * i -: 64] = key_now[i];
    return k ^ {64{pad}};
  endfunction

  // advance the HMAC state by one accepted word, queue MAC words on end
  task automatic hmac_absorb(input item_t it);
    int j;
    logic [255:0] outer;
    mac_t m;
    if (!it.byte_valid && !it.last) return;
    if (!msg_open) begin
      hash_st = sha_compress(iv_packed(), key_pad(IPAD));
      bit_cnt = 64'd512;
      fill = 0;
      msg_open = 1'b1;
    end
    if (it.byte_valid) begin
      blk_buf[511 - 8 * fill -: 8] = it.data_byte;
      fill = (fill + 1) % 64;
      if (fill == 0) begin
        hash_st = sha_compress(hash_st, blk_buf);
        bit_cnt += 64'd512;
      end
    end
    if (!it.last) return;
    j = fill;
    bit_cnt += 64'(j) * 8;
    blk_buf[511 - 8 * j -: 8] = PAD_BYTE;
    j++;
    if (j > 56) begin
      for (; j < 64; j++) blk_buf[511 - 8 * j -: 8] = 8'h00;
      hash_st = sha_compress(hash_st, blk_buf);
      j = 0;
    end
    for (; j < 56; j++) blk_buf[511 - 8 * j -: 8] = 8'h00;
    blk_buf[63:0] = bit_cnt;
    hash_st = sha_compress(hash_st, blk_buf);
    outer = sha_compress(iv_packed(), key_pad(OPAD));
    outer = sha_compress(outer, {hash_st, PAD_BYTE, 184'd0, 64'd768});
    for (int k = 0; k < 4; k++) begin
      m.mac_word = outer[255 - 64 * k -: 64];
      m.word_index = 2'(k);
      m.last_word = (k == 3);
      mac_exp = {mac_exp, m};
    end
    hash_st = iv_packed();
    fill = 0;
    bit_cnt = 64'd0;
    msg_open = 1'b0;
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
  endtask

  // message word driver
  always @(posedge clk) begin : drive_msg
    item_t it;
    if (rst) begin
      msg_valid <= 1'b0;
    end else if (!msg_valid || msg_ready) begin
      if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = word_q.pop_front();
        msg_valid <= 1'b1;
        data_byte <= it.data_byte;
        byte_valid <= it.byte_valid;
        last <= it.last;
      end else begin
        msg_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_start) hold_left <= 600;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // MAC receiver readiness
  always @(posedge clk) begin
    if (rst || hold_start || hold_left > 1) mac_ready <= 1'b0;
    else mac_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // input monitor feeds the predictor
  always @(posedge clk) begin : watch_msg
    item_t it;
    if (!rst && msg_valid && msg_ready) begin
      it.data_byte = data_byte;
      it.byte_valid = byte_valid;
      it.last = last;
      hmac_absorb(it);
    end
  end

  // output monitor checks against the oldest expected word
  always @(posedge clk) begin : watch_mac
    mac_t m;
    if (!rst && mac_valid && mac_ready) begin
      if (mac_exp.size() == 0) begin
        report("unexpected word", mac_word, 64'd0);
      end else begin
        m = mac_exp.pop_front();
        if (mac_word !== m.mac_word) report("mac_word", mac_word, m.mac_word);
        if (word_index !== m.word_index) report("word_index", 64'(word_index), 64'(m.word_index));
        if (last_word !== m.last_word) report("last_word", 64'(last_word), 64'(m.last_word));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_word(input logic [7:0] b, input logic v, input logic e);
    item_t it;
    it.data_byte = b;
    it.byte_valid = v;
    it.last = e;
    word_q = {word_q, it};
    n_sent++;
  endtask

  // queue one message; close=0 leaves it open
  task automatic queue_msg(input int len, input int noise_pct, input bit close, input int pat);
    logic [7:0] b;
    bit tail_in_last;
    tail_in_last = (len > 0) && close && $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) push_word(8'($urandom), 1'b0, 1'b0);
      case (pat)
        1: b = (i % 2) ? 8'hff : 8'h00;
        default: b = 8'($urandom);
      endcase
      push_word(b, 1'b1, (i == len - 1) && tail_in_last);
    end
    if (close && !tail_in_last) push_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (word_q.size() > 0 || msg_valid || mac_exp.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(input int idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= KEY_IDX_W'(idx);
    cfg_data <= val;
    key_now[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle(input int s, input int r);
    send_idle_pct = s;
    recv_stall_pct = r;
  endtask

  initial begin
    int len;
    for (int i = 0; i < KEY_REGS; i++) key_now[i] = 64'd0;
    hash_st = iv_packed();
    fill = 0;
    bit_cnt = 64'd0;
    msg_open = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: zero key, empty and short messages, idle words
    queue_msg(0, 0, 1'b1, 0);
    push_word(8'h5a, 1'b0, 1'b0);
    queue_msg(1, 0, 1'b1, 1);
    queue_msg(3, 50, 1'b1, 1);
    wait_drained();

    // all-ones key, lengths around the pad boundary
    for (int i = 0; i < KEY_REGS; i++) write_key(i, 64'hffff_ffff_ffff_ffff);
    queue_msg(55, 0, 1'b1, 1);
    queue_msg(56, 0, 1'b1, 0);
    queue_msg(64, 0, 1'b1, 0);
    wait_drained();

    // short key; key changed while a message is open
    for (int i = 0; i < KEY_REGS; i++) write_key(i, (i < 4) ? {$urandom, $urandom} : 64'd0);
    queue_msg(10, 0, 1'b0, 0);
    wait_drained();
    for (int i = 0; i < KEY_REGS; i++) write_key(i, {$urandom, $urandom});
    queue_msg(5, 0, 1'b1, 0);
    wait_drained();

    // random messages under the idle profiles
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_idle(0, 0);
        1: set_idle(45, 0);
        2: set_idle(0, 45);
        3: set_idle(9, 9);
        default: set_idle(0, 0);
      endcase
      if (ph == 4) hold_start <= 1'b1;
      for (int m = 0; m < 4; m++) begin
        len = (ph == 4) ? $urandom_range(8, 16) : $urandom_range(0, 6);
        queue_msg(len, 10, 1'b1, 0);
      end
      if (ph == 4) begin
        @(posedge clk);
        hold_start <= 1'b0;
      end
      wait_drained();
      if (ph == 2 || ph == 3)
        for (int i = 0; i < KEY_REGS; i++) write_key(i, {$urandom, $urandom});
    end
    set_idle(20, 20);
    while (n_sent < 330) begin
      len = $urandom_range(0, 6);
      queue_msg(len, 10, 1'b1, 0);
    end
    wait_drained();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hse_pkg.sv
rtl/hse_front.sv
rtl/hse_core.sv
rtl/hmac_sha256_engine.sv
tb/tb_hmac_sha256_engine.sv
